// ===== rtl/bat_pkg.sv =====
package bat_pkg;

  localparam int unsigned TagW  = 8;
  localparam int unsigned BankW = 8;
  localparam int unsigned KindW = 3;

  // Request kinds
  localparam logic [KindW-1:0] KIND_ALLOC      = 3'd0;
  localparam logic [KindW-1:0] KIND_FREE       = 3'd1;
  localparam logic [KindW-1:0] KIND_QUERY      = 3'd2;
  localparam logic [KindW-1:0] KIND_COUNT_FREE = 3'd3;
  localparam logic [KindW-1:0] KIND_COUNT_TAG  = 3'd4;
  localparam logic [KindW-1:0] KIND_MARK_FIXED = 3'd5;

  // Tag codes
  localparam logic [TagW-1:0] TAG_FREE     = 8'd0;
  localparam logic [TagW-1:0] TAG_SKIPPED  = 8'd1;
  localparam logic [TagW-1:0] TAG_GLOBAL   = 8'd2;
  localparam logic [TagW-1:0] TAG_LAUNCHER = 8'd3;

  localparam logic [TagW-1:0]  SAT_COUNT  = 8'hFF;
  localparam logic [BankW-1:0] ALLOC_NONE = 8'hFF;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_COUNT    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_GLOBAL_BANK   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LAUNCHER_BANK = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_DYNAMIC = 2'd3;

  localparam logic [BankW-1:0] RST_SKIP_COUNT    = 8'd0;
  localparam logic [BankW-1:0] RST_GLOBAL_BANK   = 8'd0;
  localparam logic [BankW-1:0] RST_LAUNCHER_BANK = 8'd1;
  localparam logic [BankW-1:0] RST_FIRST_DYNAMIC = 8'd2;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [TagW-1:0]  type_tag;
    logic [BankW-1:0] bank_index;
  } request_t;

  typedef struct packed {
    logic [TagW-1:0] result_value;
    logic            error;
  } result_t;

  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_ALLOC  = 3'd1,
    WR_FREE   = 3'd2,
    WR_SKIP   = 3'd3,
    WR_GLOBAL = 3'd4,
    WR_LAUNCH = 3'd5
  } wr_op_t;

  typedef enum logic [2:0] {
    RES_ZERO_OK    = 3'd0,
    RES_ZERO_ERR   = 3'd1,
    RES_ALLOC_HIT  = 3'd2,
    RES_ALLOC_FAIL = 3'd3,
    RES_QUERY      = 3'd4,
    RES_COUNT      = 3'd5,
    RES_MARK       = 3'd6
  } res_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd;
    logic     step;
    logic     acc;
    wr_op_t   wr_op;
    logic     finish;
    res_sel_t res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic alloc_hit;
    logic scan_done;
    logic bank_ok;
    logic skip_more;
  } dp_status_t;

endpackage

// ===== rtl/bank_allocation_table_top.sv =====
// Bank allocation table: keeps an 8-bit type tag per memory bank and serves
// allocate, free, query, count-free, count-tag and mark-fixed requests. A
// request is taken when start is high while busy is low; its single result
// appears on result for exactly one cycle with done high, and the receiver
// must capture it then, since nothing holds it. The single-read tag table is
// read one entry a cycle: count scans every bank, allocate scans up from
// first_dynamic and stops early on a hit, query reads one entry, free and
// mark-fixed only write, and an unknown kind is answered from idle with an
// error. The table needs no clearing pass after reset. Write configuration
// registers only while busy is low.
module bank_allocation_table_top
  import bat_pkg::*;
#(
  parameter int unsigned BANKS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  request_t           request,
  output logic               done,
  output result_t            result,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [BankW-1:0]   cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  bat_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (request.kind),
    .busy  (busy),
    .cmd   (cmd),
    .st    (st)
  );

  bat_dp #(
    .BANKS (BANKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== rtl/bat_ctrl.sv =====
module bat_ctrl
  import bat_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KindW-1:0] kind,
  output logic             busy,
  output ctrl_cmd_t        cmd,
  input  dp_status_t       st
);

  typedef enum logic [8:0] {
    S_IDLE        = 9'b000000001,
    S_ALLOC       = 9'b000000010,
    S_COUNT       = 9'b000000100,
    S_FREE        = 9'b000001000,
    S_QUERY_RD    = 9'b000010000,
    S_QUERY_RES   = 9'b000100000,
    S_MARK_SKIP   = 9'b001000000,
    S_MARK_GLOBAL = 9'b010000000,
    S_MARK_LAUNCH = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.load    = 1'b0;
    cmd.rd      = 1'b0;
    cmd.step    = 1'b0;
    cmd.acc     = 1'b0;
    cmd.wr_op   = WR_NONE;
    cmd.finish  = 1'b0;
    cmd.res_sel = RES_ZERO_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (kind)
            KIND_ALLOC:      state_next = S_ALLOC;
            KIND_FREE:       state_next = S_FREE;
            KIND_QUERY:      state_next = S_QUERY_RD;
            KIND_COUNT_FREE: state_next = S_COUNT;
            KIND_COUNT_TAG:  state_next = S_COUNT;
            KIND_MARK_FIXED: state_next = S_MARK_SKIP;
            default: begin
              cmd.finish  = 1'b1;
              cmd.res_sel = RES_ZERO_ERR;
            end
          endcase
        end
      end
      S_ALLOC: begin
        cmd.rd   = 1'b1;
        cmd.step = 1'b1;
        if (st.alloc_hit) begin
          cmd.wr_op   = WR_ALLOC;
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_ALLOC_HIT;
          state_next  = S_IDLE;
        end else if (st.scan_done) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_ALLOC_FAIL;
          state_next  = S_IDLE;
        end
      end
      S_COUNT: begin
        cmd.rd   = 1'b1;
        cmd.step = 1'b1;
        cmd.acc  = 1'b1;
        if (st.scan_done) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_COUNT;
          state_next  = S_IDLE;
        end
      end
      S_FREE: begin
        cmd.finish = 1'b1;
        if (st.bank_ok) begin
          cmd.wr_op   = WR_FREE;
          cmd.res_sel = RES_ZERO_OK;
        end else begin
          cmd.res_sel = RES_ZERO_ERR;
        end
        state_next = S_IDLE;
      end
      S_QUERY_RD: begin
        if (st.bank_ok) begin
          cmd.rd     = 1'b1;
          state_next = S_QUERY_RES;
        end else begin
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_ZERO_ERR;
          state_next  = S_IDLE;
        end
      end
      S_QUERY_RES: begin
        cmd.finish  = 1'b1;
        cmd.res_sel = RES_QUERY;
        state_next  = S_IDLE;
      end
      S_MARK_SKIP: begin
        if (st.skip_more) begin
          cmd.wr_op = WR_SKIP;
          cmd.step  = 1'b1;
        end else begin
          state_next = S_MARK_GLOBAL;
        end
      end
      S_MARK_GLOBAL: begin
        cmd.wr_op  = WR_GLOBAL;
        state_next = S_MARK_LAUNCH;
      end
      S_MARK_LAUNCH: begin
        cmd.wr_op   = WR_LAUNCH;
        cmd.finish  = 1'b1;
        cmd.res_sel = RES_MARK;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/bat_dp.sv =====
module bat_dp
  import bat_pkg::*;
#(
  parameter int unsigned BANKS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  request_t           request,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [BankW-1:0]   cfg_data,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         st,
  output logic               done,
  output result_t            result
);

  localparam int unsigned AW = $clog2(BANKS);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] PTR_END = CW'(BANKS);
  localparam logic [BankW:0] BANK_LIM = (BankW + 1)'(BANKS);

  logic [BankW-1:0] skip_count;
  logic [BankW-1:0] global_bank;
  logic [BankW-1:0] launcher_bank;
  logic [BankW-1:0] first_dynamic;

  request_t        req;
  logic [TagW-1:0] match_tag;
  logic [CW-1:0]   ptr;
  logic            rd_pend;
  logic [AW-1:0]   rd_addr;
  logic [TagW-1:0] cnt;

  logic [TagW-1:0]  mem [BANKS];
  logic [BANKS-1:0] vld;
  logic [TagW-1:0]  rd_data;
  logic             rd_vld;
  logic [TagW-1:0]  rdata;

  logic            ptr_live;
  logic            fd_ok;
  logic            glb_ok;
  logic            lnc_ok;
  logic            rd_fixed;
  logic [TagW-1:0] free_tag;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [TagW-1:0] wdata;

  function automatic logic in_range(input logic [BankW-1:0] b);
    return {1'b0, b} < BANK_LIM;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count    <= RST_SKIP_COUNT;
      global_bank   <= RST_GLOBAL_BANK;
      launcher_bank <= RST_LAUNCHER_BANK;
      first_dynamic <= RST_FIRST_DYNAMIC;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SKIP_COUNT:    skip_count    <= cfg_data;
        CFG_GLOBAL_BANK:   global_bank   <= cfg_data;
        CFG_LAUNCHER_BANK: launcher_bank <= cfg_data;
        CFG_FIRST_DYNAMIC: first_dynamic <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ptr_live = (ptr < PTR_END);
  assign fd_ok    = in_range(first_dynamic);
  assign glb_ok   = in_range(global_bank);
  assign lnc_ok   = in_range(launcher_bank);
  assign rdata    = rd_vld ? rd_data : TAG_FREE;

  assign rd_fixed = (BankW'(rd_addr) < skip_count) || (BankW'(rd_addr) == global_bank) ||
                    (BankW'(rd_addr) == launcher_bank);

  always_comb begin
    priority if (req.bank_index < skip_count) begin
      free_tag = TAG_SKIPPED;
    end else if (req.bank_index == global_bank) begin
      free_tag = TAG_GLOBAL;
    end else if (req.bank_index == launcher_bank) begin
      free_tag = TAG_LAUNCHER;
    end else begin
      free_tag = TAG_FREE;
    end
  end

  assign st.alloc_hit = rd_pend && !rd_fixed && (rdata == TAG_FREE);
  assign st.scan_done = !rd_pend && !ptr_live;
  assign st.bank_ok   = in_range(req.bank_index);
  assign st.skip_more = ptr_live && ((BankW + 1)'(ptr) < (BankW + 1)'(skip_count));

  // Request latch, scan pointer and counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req       <= request;
      match_tag <= (request.kind == KIND_COUNT_FREE) ? TAG_FREE : request.type_tag;
      cnt       <= '0;
      unique case (request.kind)
        KIND_ALLOC: ptr <= fd_ok ? CW'(first_dynamic) : PTR_END;
        KIND_QUERY: ptr <= in_range(request.bank_index) ? CW'(request.bank_index) : PTR_END;
        default:    ptr <= '0;
      endcase
    end else begin
      if (cmd.step && ptr_live) begin
        ptr <= ptr + CW'(1);
      end
      if (cmd.acc && rd_pend && (rdata == match_tag) && (cnt != SAT_COUNT)) begin
        cnt <= cnt + TagW'(1);
      end
    end
    rd_addr <= ptr[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.rd && ptr_live && !cmd.load;
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = ptr[AW-1:0];
    wdata = TAG_FREE;
    unique case (cmd.wr_op)
      WR_ALLOC: begin
        waddr = rd_addr;
        wdata = req.type_tag;
      end
      WR_FREE: begin
        waddr = req.bank_index[AW-1:0];
        wdata = free_tag;
      end
      WR_SKIP: begin
        wdata = TAG_SKIPPED;
      end
      WR_GLOBAL: begin
        we    = glb_ok;
        waddr = global_bank[AW-1:0];
        wdata = TAG_GLOBAL;
      end
      WR_LAUNCH: begin
        we    = lnc_ok;
        waddr = launcher_bank[AW-1:0];
        wdata = TAG_LAUNCHER;
      end
      default: we = 1'b0;
    endcase
  end

  // Tag table: entries not yet written read as free
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[ptr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[ptr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      unique case (cmd.res_sel)
        RES_ZERO_OK: begin
          result.result_value <= '0;
          result.error        <= 1'b0;
        end
        RES_ZERO_ERR: begin
          result.result_value <= '0;
          result.error        <= 1'b1;
        end
        RES_ALLOC_HIT: begin
          result.result_value <= TagW'(rd_addr);
          result.error        <= 1'b0;
        end
        RES_ALLOC_FAIL: begin
          result.result_value <= ALLOC_NONE;
          result.error        <= 1'b1;
        end
        RES_QUERY: begin
          result.result_value <= rdata;
          result.error        <= 1'b0;
        end
        RES_COUNT: begin
          result.result_value <= cnt;
          result.error        <= 1'b0;
        end
        RES_MARK: begin
          result.result_value <= '0;
          result.error        <= !(glb_ok && lnc_ok);
        end
        default: begin
          result.result_value <= '0;
          result.error        <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import bat_pkg::*;

  localparam int NUM_BANKS    = 256;
  localparam int RANDOM_ITEMS = 1480;
  localparam int DRAIN_LIMIT  = 2 * NUM_BANKS + 16;
  localparam int REPORT_LIMIT = 10;

  // The two kind codes the block does not define
  localparam logic [KindW-1:0] KIND_RSVD_A = 3'd6;
  localparam logic [KindW-1:0] KIND_RSVD_B = 3'd7;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  request_t           request;
  logic               done;
  result_t            result;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [BankW-1:0]   cfg_data;

  // Shadow copy of the bank table and its registers
  logic [TagW-1:0]  bank_tags [NUM_BANKS];
  logic [BankW-1:0] skip_banks;
  logic [BankW-1:0] global_idx;
  logic [BankW-1:0] launcher_idx;
  logic [BankW-1:0] scan_base;

  result_t pending_replies [$];
  result_t oldest_reply;
  int      mismatch_count;
  bit      no_idle;

  bank_allocation_table_top #(
    .BANKS(NUM_BANKS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [TagW-1:0] fixed_tag_of(int bank);
    if (bank < int'(skip_banks)) return TAG_SKIPPED;
    if (bank == int'(global_idx)) return TAG_GLOBAL;
    if (bank == int'(launcher_idx)) return TAG_LAUNCHER;
    return TAG_FREE;
  endfunction

  function automatic logic [TagW-1:0] count_tagged(logic [TagW-1:0] tag);
    int i;
    int n;
    n = 0;
    for (i = 0; i < NUM_BANKS; i++) begin
      if (bank_tags[BankW'(i)] == tag && n < int'(SAT_COUNT)) n++;
    end
    return TagW'(n);
  endfunction

  // Apply one request to the shadow table and return the reply it produces
  function automatic result_t serve_request(request_t req);
    result_t reply;
    int      i;
    reply.result_value = '0;
    reply.error        = 1'b0;
    case (req.kind)
      KIND_ALLOC: begin
        reply.result_value = ALLOC_NONE;
        reply.error        = 1'b1;
        for (i = int'(scan_base); i < NUM_BANKS; i++) begin
          if (fixed_tag_of(i) == TAG_FREE && bank_tags[BankW'(i)] == TAG_FREE) begin
            bank_tags[BankW'(i)] = req.type_tag;
            reply.result_value   = BankW'(i);
            reply.error          = 1'b0;
            break;
          end
        end
      end
      KIND_FREE: begin
        if (int'(req.bank_index) >= NUM_BANKS) reply.error = 1'b1;
        else bank_tags[req.bank_index] = fixed_tag_of(int'(req.bank_index));
      end
      KIND_QUERY: begin
        if (int'(req.bank_index) >= NUM_BANKS) reply.error = 1'b1;
        else reply.result_value = bank_tags[req.bank_index];
      end
      KIND_COUNT_FREE: reply.result_value = count_tagged(TAG_FREE);
      KIND_COUNT_TAG:  reply.result_value = count_tagged(req.type_tag);
      KIND_MARK_FIXED: begin
        for (i = 0; i < int'(skip_banks) && i < NUM_BANKS; i++)
          bank_tags[BankW'(i)] = TAG_SKIPPED;
        if (int'(global_idx) < NUM_BANKS) bank_tags[global_idx] = TAG_GLOBAL;
        else reply.error = 1'b1;
        if (int'(launcher_idx) < NUM_BANKS) bank_tags[launcher_idx] = TAG_LAUNCHER;
        else reply.error = 1'b1;
      end
      default: reply.error = 1'b1;
    endcase
    return reply;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic logic [TagW-1:0] pick_tag();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return TAG_FREE;
    if (r < 30) return TagW'($urandom_range(TAG_SKIPPED, TAG_LAUNCHER));
    if (r < 40) return SAT_COUNT;
    return TagW'($urandom_range(0, 255));
  endfunction

  task automatic issue(input logic [KindW-1:0] kind, input logic [TagW-1:0] tag,
                       input logic [BankW-1:0] bank);
    request_t req;
    int       gap;
    req.kind       = kind;
    req.type_tag   = tag;
    req.bank_index = bank;
    @(negedge clk);
    start   = 1'b1;
    request = req;
    do @(posedge clk); while (busy);
    pending_replies.push_back(serve_request(req));
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    start = 1'b0;
    while (pending_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [BankW-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      CFG_SKIP_COUNT:    skip_banks   = value;
      CFG_GLOBAL_BANK:   global_idx   = value;
      CFG_LAUNCHER_BANK: launcher_idx = value;
      CFG_FIRST_DYNAMIC: scan_base    = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(input logic [BankW-1:0] skip, input logic [BankW-1:0] glob,
                            input logic [BankW-1:0] launch, input logic [BankW-1:0] first);
    write_reg(CFG_SKIP_COUNT, skip);
    write_reg(CFG_GLOBAL_BANK, glob);
    write_reg(CFG_LAUNCHER_BANK, launch);
    write_reg(CFG_FIRST_DYNAMIC, first);
  endtask

  // Every operation, and both undefined kinds, under the reset configuration
  task automatic test_basic_ops();
    issue(KIND_COUNT_FREE, 8'h00, 8'h00);   // all banks free: count saturates
    issue(KIND_COUNT_TAG, TAG_FREE, 8'h00);
    issue(KIND_QUERY, 8'h00, 8'h00);
    issue(KIND_QUERY, 8'h00, 8'hFF);
    issue(KIND_MARK_FIXED, 8'h00, 8'h00);
    issue(KIND_COUNT_FREE, 8'h00, 8'h00);
    issue(KIND_ALLOC, 8'hFF, 8'h00);
    issue(KIND_ALLOC, TAG_FREE, 8'h00);     // leaves the bank free
    issue(KIND_ALLOC, 8'h80, 8'h00);
    issue(KIND_QUERY, 8'h00, 8'h02);
    issue(KIND_COUNT_TAG, 8'hFF, 8'h00);
    issue(KIND_FREE, 8'h00, 8'h00);         // fixed bank: tag restored
    issue(KIND_FREE, 8'h00, 8'h01);
    issue(KIND_FREE, 8'h00, 8'h02);
    issue(KIND_FREE, 8'h00, 8'hFF);
    issue(KIND_RSVD_A, 8'hA5, 8'h5A);
    issue(KIND_RSVD_B, 8'hFF, 8'hFF);
    issue(KIND_COUNT_TAG, TAG_LAUNCHER, 8'h00);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    issue(KIND_ALLOC, 8'h5A, 8'h00);        // only candidate is fixed: fails
    issue(KIND_MARK_FIXED, 8'h00, 8'h00);
    issue(KIND_QUERY, 8'h00, 8'hFE);
    issue(KIND_COUNT_TAG, TAG_SKIPPED, 8'h00);
    wait_idle();
    set_config(8'h00, 8'h00, 8'h01, 8'hFF);
    issue(KIND_FREE, 8'h00, 8'hFF);
    issue(KIND_ALLOC, 8'hC3, 8'h00);        // top bank, no error
    issue(KIND_ALLOC, 8'h3C, 8'h00);        // table exhausted
  endtask

  task automatic test_random_traffic();
    int sent;
    int phase_len;
    int k;
    int r;
    logic [BankW-1:0] skip;
    logic [BankW-1:0] glob;
    logic [BankW-1:0] launch;
    logic [BankW-1:0] first;
    logic [BankW-1:0] bank;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 50) skip = BankW'($urandom_range(0, 6));
      else if (r < 75) skip = BankW'($urandom_range(0, 255));
      else if (r < 85) skip = 8'hFF;
      else skip = 8'h00;
      glob   = ($urandom_range(0, 1) == 0) ? BankW'($urandom_range(0, 15))
                                           : BankW'($urandom_range(0, 255));
      launch = ($urandom_range(0, 1) == 0) ? BankW'($urandom_range(0, 15))
                                           : BankW'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 40) first = BankW'($urandom_range(200, 255));
      else if (r < 70) first = BankW'($urandom_range(0, 8));
      else first = BankW'($urandom_range(0, 255));
      set_config(skip, glob, launch, first);
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(60, 140);
      for (k = 0; k < phase_len; k++) begin
        r    = $urandom_range(0, 99);
        bank = ($urandom_range(0, 99) < 70) ? BankW'($urandom_range(scan_base, 255))
                                            : BankW'($urandom_range(0, 255));
        if (r < 32) issue(KIND_ALLOC, pick_tag(), BankW'($urandom_range(0, 255)));
        else if (r < 66) issue(KIND_FREE, TagW'($urandom_range(0, 255)), bank);
        else if (r < 78) issue(KIND_QUERY, TagW'($urandom_range(0, 255)), bank);
        else if (r < 83) issue(KIND_COUNT_FREE, TagW'($urandom_range(0, 255)), bank);
        else if (r < 89) issue(KIND_COUNT_TAG, pick_tag(), bank);
        else if (r < 95) issue(KIND_MARK_FIXED, TagW'($urandom_range(0, 255)), bank);
        else if (r < 98) issue(KIND_RSVD_A, TagW'($urandom_range(0, 255)), bank);
        else issue(KIND_RSVD_B, TagW'($urandom_range(0, 255)), bank);
      end
      sent += phase_len;
    end
    no_idle = 1'b0;
  endtask

  // Match each reply transaction against the oldest outstanding one
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_replies.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected transaction: result_value %0d error %0b",
                   result.result_value, result.error);
        mismatch_count++;
      end else begin
        oldest_reply = pending_replies.pop_front();
        if (result.result_value !== oldest_reply.result_value ||
            result.error !== oldest_reply.error) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("mismatch at %0t: result_value exp %0d got %0d, error exp %0b got %0b",
                     $realtime, oldest_reply.result_value, result.result_value,
                     oldest_reply.error, result.error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int i;
    clk            = 1'b0;
    rst            = 1'b1;
    start          = 1'b0;
    request        = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SKIP_COUNT;
    cfg_data       = '0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    for (i = 0; i < NUM_BANKS; i++) bank_tags[BankW'(i)] = TAG_FREE;
    skip_banks   = RST_SKIP_COUNT;
    global_idx   = RST_GLOBAL_BANK;
    launcher_idx = RST_LAUNCHER_BANK;
    scan_base    = RST_FIRST_DYNAMIC;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_ops();
    test_register_extremes();
    test_random_traffic();

    wait_idle();
    repeat (NUM_BANKS + 8) @(posedge clk);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bat_pkg.sv
rtl/bat_ctrl.sv
rtl/bat_dp.sv
rtl/bank_allocation_table_top.sv
dv/tb_top.sv
